>>> src/tfcc_pkg.sv
// shared types and constants for the tcp flow connection counter
// used by tfcc_ctrl, tfcc_datapath and tcp_flow_connection_counter; no dependencies
package tfcc_pkg;

  localparam int DEF_TABLE_ENTRIES = 1024;
  localparam int DEF_TABLE_WAYS    = 4;

  localparam logic [7:0] PROTO_TCP = 8'd6;

  localparam logic [31:0] HASH_C1 = 32'h9E37_79B1;
  localparam logic [31:0] HASH_C2 = 32'h85EB_CA6B;
  localparam logic [31:0] HASH_C3 = 32'h7FEB_352D;

  typedef struct packed {
    logic        valid;
    logic [63:0] addrs;
    logic [31:0] ports;
    logic        open;
    logic [31:0] count;
  } entry_t;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_HASH1  = 9'b000000100,
    ST_HASH2  = 9'b000001000,
    ST_HASH3  = 9'b000010000,
    ST_DIVLD  = 9'b000100000,
    ST_DIV    = 9'b001000000,
    ST_READ   = 9'b010000000,
    ST_UPDATE = 9'b100000000
  } state_e;

  typedef struct packed {
    logic in_load;
    logic hash1;
    logic hash2;
    logic hash3;
    logic div_load;
    logic div_step;
    logic mem_read;
    logic update;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> src/tfcc_ctrl.sv
// sequencer for the flow counter: clearing pass, hash, remainder, read and update
// depends on tfcc_pkg
module tfcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tfcc_pkg::ctrl_sts_t sts_i,
  output tfcc_pkg::ctrl_cmd_t cmd_o
);

  tfcc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfcc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      tfcc_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = tfcc_pkg::ST_IDLE;
      end
      tfcc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = tfcc_pkg::ST_HASH1;
        end
      end
      tfcc_pkg::ST_HASH1: begin
        cmd_o.hash1 = 1'b1;
        state_d     = tfcc_pkg::ST_HASH2;
      end
      tfcc_pkg::ST_HASH2: begin
        cmd_o.hash2 = 1'b1;
        state_d     = tfcc_pkg::ST_HASH3;
      end
      tfcc_pkg::ST_HASH3: begin
        cmd_o.hash3 = 1'b1;
        state_d     = tfcc_pkg::ST_DIVLD;
      end
      tfcc_pkg::ST_DIVLD: begin
        cmd_o.div_load = 1'b1;
        state_d        = tfcc_pkg::ST_DIV;
      end
      tfcc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = tfcc_pkg::ST_READ;
      end
      tfcc_pkg::ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = tfcc_pkg::ST_UPDATE;
      end
      tfcc_pkg::ST_UPDATE: begin
        // hold until the output register can take the beat
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = tfcc_pkg::ST_IDLE;
        end
      end
      default: state_d = tfcc_pkg::ST_CLEAR;
    endcase
  end

endmodule

>>> src/tfcc_datapath.sv
// datapath of the flow counter: header registers, hash, set remainder,
// flow table memory, way compare and update, output register; depends on tfcc_pkg
module tfcc_datapath #(
  parameter int TABLE_ENTRIES = tfcc_pkg::DEF_TABLE_ENTRIES,
  parameter int TABLE_WAYS    = tfcc_pkg::DEF_TABLE_WAYS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfcc_pkg::ctrl_cmd_t cmd_i,
  output tfcc_pkg::ctrl_sts_t sts_o,
  input  logic [7:0]          protocol_i,
  input  logic [31:0]         src_addr_i,
  input  logic [31:0]         dst_addr_i,
  input  logic [15:0]         src_port_i,
  input  logic [15:0]         dst_port_i,
  input  logic                syn_flag_i,
  input  logic                fin_flag_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         total_closed_o,
  output logic [31:0]         flow_closed_o,
  output logic                flow_is_open_o,
  output logic                ignored_o,
  output logic                table_full_o
);

  localparam int NUM_SETS = TABLE_ENTRIES / TABLE_WAYS;
  localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int RW       = SET_W + 1;
  localparam int WAY_W    = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
  localparam logic [RW-1:0] NUM_SETS_R = RW'(NUM_SETS);
  localparam logic [31:0]   RECIP      = 32'(64'h0000_0000_FFFF_FFFF / 64'(NUM_SETS));

  typedef tfcc_pkg::entry_t [TABLE_WAYS-1:0] row_t;

  // header registers
  logic [7:0]  proto_q;
  logic [31:0] sa_q, da_q;
  logic [15:0] sp_q, dp_q;
  logic        syn_q, fin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      proto_q <= protocol_i;
      sa_q    <= src_addr_i;
      da_q    <= dst_addr_i;
      sp_q    <= src_port_i;
      dp_q    <= dst_port_i;
      syn_q   <= syn_flag_i;
      fin_q   <= fin_flag_i;
    end
  end

  // hash, one multiply per cycle
  logic [31:0] h_q, h_d, mix;

  always_comb begin
    mix = h_q ^ (h_q >> 16);
    h_d = h_q;
    if (cmd_i.hash1) h_d = da_q * tfcc_pkg::HASH_C1;
    if (cmd_i.hash2) h_d = sa_q ^ h_q ^ ({sp_q, dp_q} * tfcc_pkg::HASH_C2);
    if (cmd_i.hash3) h_d = mix * tfcc_pkg::HASH_C3;
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end

  // set index = (hash ^ hash >> 15) mod NUM_SETS by reciprocal multiply; the quotient
  // estimate is low by at most one, so one compare and subtract fixes it
  logic [31:0]   mval;
  logic [63:0]   prod;
  logic [RW-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [RW-1:0] rem_q, rem_d, rem_v;

  always_comb begin
    mval  = h_q ^ (h_q >> 15);
    prod  = 64'(mval) * 64'(RECIP);
    rem_v = dvd_q - RW'(quo_q * NUM_SETS_R);
    if (rem_v >= NUM_SETS_R) rem_v = rem_v - NUM_SETS_R;
    dvd_d = dvd_q;
    quo_d = quo_q;
    rem_d = rem_q;
    if (cmd_i.div_load) begin
      dvd_d = mval[RW-1:0];
      quo_d = prod[32 +: RW];
    end
    if (cmd_i.div_step) rem_d = rem_v;
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  logic [SET_W-1:0] set_idx;
  assign set_idx = rem_q[SET_W-1:0];

  // clearing pass index
  logic [SET_W-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear) begin
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  assign sts_o.clr_last = (clr_idx_q == SET_W'(NUM_SETS - 1));

  // flow table, one row per set
  row_t             mem_q [NUM_SETS];
  row_t             rd_row_q;
  row_t             wr_row;
  logic             mem_we;
  logic [SET_W-1:0] mem_idx;
  row_t             mem_wdata;

  // way compare and entry update
  logic              tcp, hit, free, full, inc;
  logic [WAY_W-1:0]  hit_idx, free_idx, slot;
  tfcc_pkg::entry_t  cur, nxt;
  logic [31:0]       total_next;

  always_comb begin
    tcp      = (proto_q == tfcc_pkg::PROTO_TCP);
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      if (!hit && rd_row_q[w].valid && rd_row_q[w].addrs == {sa_q, da_q} &&
          rd_row_q[w].ports == {sp_q, dp_q}) begin
        hit     = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (!free && !rd_row_q[w].valid) begin
        free     = 1'b1;
        free_idx = WAY_W'(w);
      end
    end
    full = !hit && !free;
    slot = hit ? hit_idx : free_idx;
    if (hit) begin
      cur = rd_row_q[hit_idx];
    end else begin
      cur.valid = 1'b1;
      cur.addrs = {sa_q, da_q};
      cur.ports = {sp_q, dp_q};
      cur.open  = 1'b0;
      cur.count = '0;
    end
    nxt = cur;
    inc = 1'b0;
    // fin is checked before syn
    if (fin_q && cur.open) begin
      nxt.count = cur.count + 32'd1;
      nxt.open  = 1'b0;
      inc       = 1'b1;
    end
    if (syn_q && !nxt.open) nxt.open = 1'b1;
    wr_row       = rd_row_q;
    wr_row[slot] = nxt;
  end

  logic commit;
  assign commit = cmd_i.update && tcp && !full;

  always_comb begin
    mem_we    = commit || cmd_i.clear;
    mem_idx   = cmd_i.clear ? clr_idx_q : set_idx;
    mem_wdata = cmd_i.clear ? row_t'('0) : wr_row;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_idx] <= mem_wdata;
    if (cmd_i.mem_read) rd_row_q <= mem_q[set_idx];
  end

  // global total
  logic [31:0] total_q;

  assign total_next = (commit && inc) ? total_q + 32'd1 : total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_next;
    end
  end

  // output register
  logic        out_valid_q;
  logic [31:0] o_total_q, o_flow_q;
  logic        o_open_q, o_ign_q, o_full_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      o_total_q <= total_next;
      o_flow_q  <= commit ? nxt.count : 32'd0;
      o_open_q  <= commit ? nxt.open : 1'b0;
      o_ign_q   <= !tcp;
      o_full_q  <= tcp && full;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign total_closed_o = o_total_q;
  assign flow_closed_o  = o_flow_q;
  assign flow_is_open_o = o_open_q;
  assign ignored_o      = o_ign_q;
  assign table_full_o   = o_full_q;

endmodule

>>> src/tcp_flow_connection_counter.sv
// Per-flow TCP connection counter. Each input beat carries one packet's parsed
// header; one result beat follows per packet. Flows live in a set-associative
// table of TABLE_WAYS ways per set, one memory row per set. A packet passes
// through these steps in order: accept in ST_IDLE, the hash states ST_HASH1,
// ST_HASH2 and ST_HASH3 (one multiplier each), a reciprocal multiply and a
// correction for the set-index remainder, a row read, and a compare/update that
// writes the row back unless the packet is not TCP or the set is full. The next
// packet is taken as soon as the update is done, even while its result still
// waits on out_stall_i. After reset the block clears the table one row per cycle
// (TABLE_ENTRIES / TABLE_WAYS rows, 256 by default) with in_stall_o held high.
// Depends on tfcc_pkg, tfcc_ctrl and tfcc_datapath.
module tcp_flow_connection_counter #(
  parameter int TABLE_ENTRIES = tfcc_pkg::DEF_TABLE_ENTRIES,
  parameter int TABLE_WAYS    = tfcc_pkg::DEF_TABLE_WAYS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  protocol_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic        syn_flag_i,
  input  logic        fin_flag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] total_closed_o,
  output logic [31:0] flow_closed_o,
  output logic        flow_is_open_o,
  output logic        ignored_o,
  output logic        table_full_o
);

  tfcc_pkg::ctrl_cmd_t cmd;
  tfcc_pkg::ctrl_sts_t sts;

  tfcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tfcc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TABLE_WAYS    (TABLE_WAYS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .protocol_i     (protocol_i),
    .src_addr_i     (src_addr_i),
    .dst_addr_i     (dst_addr_i),
    .src_port_i     (src_port_i),
    .dst_port_i     (dst_port_i),
    .syn_flag_i     (syn_flag_i),
    .fin_flag_i     (fin_flag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .total_closed_o (total_closed_o),
    .flow_closed_o  (flow_closed_o),
    .flow_is_open_o (flow_is_open_o),
    .ignored_o      (ignored_o),
    .table_full_o   (table_full_o)
  );

endmodule
